// File: rtl/bdwe_pkg.sv
// Shared types and constants for the 2x2 block decimator with error measure.
package bdwe_pkg;

  // Pixel lanes: top left, bottom left, top right, bottom right
  localparam int NUM_LANES = 4;
  localparam int NUM_CHAN  = 3;

  localparam int LANE_TL = 0;
  localparam int LANE_BL = 1;
  localparam int LANE_TR = 2;
  localparam int LANE_BR = 3;

  // Channel order inside a packed pixel, red at the top
  localparam int CHAN_RED   = 0;
  localparam int CHAN_GREEN = 1;
  localparam int CHAN_BLUE  = 2;

  // Column / row count code meaning "only one present"
  localparam logic [1:0] COUNT_ONE = 2'd1;

  // Merge threshold after reset: 0.5 with four fraction bits
  localparam int THRESHOLD_RESET = 8;

  // Per-block control carried alongside the data
  typedef struct packed {
    logic [NUM_LANES-1:0] present;  // pixel present, one bit per lane
    logic [1:0]           shift;    // log2 of the pixel count
  } bdwe_ctl_t;

endpackage

// File: rtl/bdwe_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module bdwe_sqrt import bdwe_pkg::*; #(
  parameter int ROOT_BITS = 13
) (
  input  logic                     clk,
  input  logic [ROOT_BITS-1:0]     en,
  input  logic [2*ROOT_BITS-1:0]   rad_in,
  output logic [ROOT_BITS-1:0]     root_out
);

  // Remainder stays below 2*root+1; three extra bits cover the shifted value
  localparam int W = ROOT_BITS + 3;

  logic [W-1:0]           rem_r  [ROOT_BITS-1];
  logic [2*ROOT_BITS-1:0] rad_r  [ROOT_BITS-1];
  logic [ROOT_BITS-1:0]   root_r [ROOT_BITS];

  genvar j;
  generate
    for (j = 0; j < ROOT_BITS; j++) begin : g_stage
      logic [W-1:0]           rem_in;
      logic [ROOT_BITS-1:0]   root_in;
      logic [2*ROOT_BITS-1:0] rad_prev;
      logic [W-1:0]           rem_sh;
      logic [W-1:0]           trial;
      logic                   ge;

      if (j == 0) begin : g_first
        assign rem_in   = '0;
        assign root_in  = '0;
        assign rad_prev = rad_in;
      end else begin : g_next
        assign rem_in   = rem_r[j-1];
        assign root_in  = root_r[j-1];
        assign rad_prev = rad_r[j-1];
      end

      // Bring down two radicand bits, try root*4+1
      always_comb begin
        rem_sh = {rem_in[W-3:0], rad_prev[2*ROOT_BITS-1 -: 2]};
        trial  = {1'b0, root_in, 2'b01};
        ge     = (rem_sh >= trial);
      end

      always_ff @(posedge clk) begin
        if (en[j]) begin
          root_r[j] <= {root_in[ROOT_BITS-2:0], ge};
        end
      end

      if (j < ROOT_BITS - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en[j]) begin
            rem_r[j] <= ge ? (rem_sh - trial) : rem_sh;
            rad_r[j] <= {rad_prev[2*ROOT_BITS-3:0], 2'b00};
          end
        end
      end
    end
  endgenerate

  assign root_out = root_r[ROOT_BITS-1];

endmodule

// File: rtl/bdwe_lane.sv
// One pixel lane: squared colour distance to the mean, then its floor root.
module bdwe_lane import bdwe_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 en_sq,
  input  logic                                 en_rad,
  input  logic [CHANNEL_BITS+4:0]              en_sqrt,
  input  logic [NUM_CHAN*CHANNEL_BITS-1:0]     pixel,
  input  logic [NUM_CHAN*(CHANNEL_BITS+2)-1:0] mean4,
  output logic [CHANNEL_BITS+4:0]              root
);

  localparam int MEAN_BITS = CHANNEL_BITS + 2;
  localparam int SQ_BITS   = 2 * MEAN_BITS;
  localparam int SUM_BITS  = SQ_BITS + 2;
  localparam int ROOT_BITS = CHANNEL_BITS + 5;

  logic [SQ_BITS-1:0]     sq_nxt [NUM_CHAN];
  logic [SQ_BITS-1:0]     sq_r   [NUM_CHAN];
  logic [SUM_BITS-1:0]    dist_sum;
  logic [2*ROOT_BITS-1:0] rad_r;

  // Per channel: |4p - mean4| squared
  always_comb begin
    logic [MEAN_BITS-1:0] a;
    logic [MEAN_BITS-1:0] m;
    logic [MEAN_BITS-1:0] d;
    for (int c = 0; c < NUM_CHAN; c++) begin
      a = {pixel[(NUM_CHAN-1-c)*CHANNEL_BITS +: CHANNEL_BITS], 2'b00};
      m = mean4[(NUM_CHAN-1-c)*MEAN_BITS +: MEAN_BITS];
      d = (a >= m) ? (a - m) : (m - a);
      sq_nxt[c] = d * d;
    end
  end

  always_ff @(posedge clk) begin
    if (en_sq) begin
      sq_r <= sq_nxt;
    end
  end

  // Sum over channels, scale by 16 for four fraction bits of the root
  assign dist_sum = SUM_BITS'(sq_r[CHAN_RED]) + SUM_BITS'(sq_r[CHAN_GREEN])
                  + SUM_BITS'(sq_r[CHAN_BLUE]);

  always_ff @(posedge clk) begin
    if (en_rad) begin
      rad_r <= {dist_sum, 4'b0000};
    end
  end

  bdwe_sqrt #(
    .ROOT_BITS (ROOT_BITS)
  ) u_sqrt (
    .clk      (clk),
    .en       (en_sqrt),
    .rad_in   (rad_r),
    .root_out (root)
  );

endmodule

// File: rtl/bdwe_merge.sv
// Merge stage: averages the lane distances, compares to threshold, output register.
module bdwe_merge import bdwe_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic [NUM_LANES-1:0][CHANNEL_BITS+4:0]    roots,
  input  bdwe_ctl_t                                 ctl,
  input  logic [NUM_CHAN*(CHANNEL_BITS+2)-1:0]      mean4,
  input  logic [CHANNEL_BITS+4:0]                   threshold,
  output logic [CHANNEL_BITS+1:0]                   mean_red,
  output logic [CHANNEL_BITS+1:0]                   mean_green,
  output logic [CHANNEL_BITS+1:0]                   mean_blue,
  output logic [CHANNEL_BITS+4:0]                   block_error,
  output logic                                      merge_block
);

  localparam int MEAN_BITS  = CHANNEL_BITS + 2;
  localparam int ROOT_BITS  = CHANNEL_BITS + 5;
  localparam int ESUM_BITS  = ROOT_BITS + 2;

  logic [ESUM_BITS-1:0] err_sum;
  logic [ESUM_BITS-1:0] err_avg;
  logic [ROOT_BITS-1:0] err_nxt;

  // Sum distances of present pixels, divide by count with a shift
  always_comb begin
    err_sum = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (ctl.present[i]) begin
        err_sum = err_sum + ESUM_BITS'(roots[i]);
      end
    end
    err_avg = err_sum >> ctl.shift;
    err_nxt = err_avg[ROOT_BITS-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (en) begin
      mean_red    <= mean4[(NUM_CHAN-1-CHAN_RED)*MEAN_BITS +: MEAN_BITS];
      mean_green  <= mean4[(NUM_CHAN-1-CHAN_GREEN)*MEAN_BITS +: MEAN_BITS];
      mean_blue   <= mean4[(NUM_CHAN-1-CHAN_BLUE)*MEAN_BITS +: MEAN_BITS];
      block_error <= err_nxt;
      merge_block <= (err_nxt < threshold);
    end
  end

endmodule

// File: rtl/block_decimate_with_error.sv
// Top level: 2x2 box downsample with mean colour distance and merge flag.
// Stages in order: input register, mean, square, sum, one stage per root bit, merge.
// Throughput: one block per cycle while out_stall is low; each square root stage resolves
// one bit per clock.
// Any empty stage lets a new block in while a finished result waits for its transfer.
// Reset (rst_n low, synchronous): all stages empty, merge threshold back to 0.5.
module block_decimate_with_error import bdwe_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [CHANNEL_BITS+4:0]      cfg_wr_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3*CHANNEL_BITS-1:0]    in_pixel_top_left,
  input  logic [3*CHANNEL_BITS-1:0]    in_pixel_bottom_left,
  input  logic [3*CHANNEL_BITS-1:0]    in_pixel_top_right,
  input  logic [3*CHANNEL_BITS-1:0]    in_pixel_bottom_right,
  input  logic [1:0]                   in_columns_present,
  input  logic [1:0]                   in_rows_present,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CHANNEL_BITS+1:0]      out_mean_red,
  output logic [CHANNEL_BITS+1:0]      out_mean_green,
  output logic [CHANNEL_BITS+1:0]      out_mean_blue,
  output logic [CHANNEL_BITS+4:0]      out_block_error,
  output logic                         out_merge_block
);

  localparam int PIX_BITS   = NUM_CHAN * CHANNEL_BITS;
  localparam int MEAN_BITS  = CHANNEL_BITS + 2;
  localparam int ERROR_BITS = CHANNEL_BITS + 5;
  localparam int ROOT_BITS  = CHANNEL_BITS + 5;
  localparam int NUM_STAGES = ROOT_BITS + 5;
  localparam int ST_MEAN    = 1;
  localparam int ST_SQ      = 2;
  localparam int ST_RAD     = 3;
  localparam int ST_ROOT0   = 4;
  localparam int ST_OUT     = NUM_STAGES - 1;
  localparam int CTL_BITS   = $bits(bdwe_ctl_t);
  localparam int SIDE_W     = NUM_CHAN * MEAN_BITS + CTL_BITS;
  localparam logic [MEAN_BITS-1:0] MEAN_MAX = {{CHANNEL_BITS{1'b1}}, 2'b00};

  logic [ERROR_BITS-1:0] threshold_r;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_in;
  logic [NUM_STAGES-1:0] rdy;
  logic [NUM_STAGES-1:0] en;

  logic [PIX_BITS-1:0]   pix0_r [NUM_LANES];
  bdwe_ctl_t             ctl0_r;
  bdwe_ctl_t             ctl_in;
  logic [PIX_BITS-1:0]   pix1_r [NUM_LANES];
  logic [SIDE_W-1:0]     side_r [ST_MEAN:ST_OUT-1];
  logic [NUM_CHAN*MEAN_BITS-1:0] mean_nxt;

  logic [NUM_LANES-1:0][ROOT_BITS-1:0] roots;
  bdwe_ctl_t             ctl_out;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= ERROR_BITS'(THRESHOLD_RESET);
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  // Stage flow: a stage loads when it or any later stage is empty, or the output is not stalled
  assign v_in = {v_r[NUM_STAGES-2:0], in_valid};

  genvar gi;
  generate
    for (gi = 0; gi < NUM_STAGES; gi++) begin : g_rdy
      assign rdy[gi] = !out_stall || !(&v_r[NUM_STAGES-1:gi]);
    end
  endgenerate

  assign en        = rdy & v_in;
  assign in_stall  = !rdy[0];
  assign out_valid = v_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  // Decode column / row counts; anything but one means both present
  always_comb begin
    logic two_cols;
    logic two_rows;
    two_cols = (in_columns_present != COUNT_ONE);
    two_rows = (in_rows_present != COUNT_ONE);
    ctl_in.present[LANE_TL] = 1'b1;
    ctl_in.present[LANE_BL] = two_rows;
    ctl_in.present[LANE_TR] = two_cols;
    ctl_in.present[LANE_BR] = two_rows & two_cols;
    ctl_in.shift            = {1'b0, two_cols} + {1'b0, two_rows};
  end

  // Input register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix0_r[LANE_TL] <= in_pixel_top_left;
      pix0_r[LANE_BL] <= in_pixel_bottom_left;
      pix0_r[LANE_TR] <= in_pixel_top_right;
      pix0_r[LANE_BR] <= in_pixel_bottom_right;
      ctl0_r          <= ctl_in;
    end
  end

  // Mean of present pixels times four
  always_comb begin
    logic [MEAN_BITS-1:0]   sum;
    logic [MEAN_BITS+1:0]   scaled;
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        if (ctl0_r.present[i]) begin
          sum = sum + MEAN_BITS'(pix0_r[i][(NUM_CHAN-1-c)*CHANNEL_BITS +: CHANNEL_BITS]);
        end
      end
      scaled = {sum, 2'b00} >> ctl0_r.shift;
      mean_nxt[(NUM_CHAN-1-c)*MEAN_BITS +: MEAN_BITS] = scaled[MEAN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_MEAN]) begin
      pix1_r          <= pix0_r;
      side_r[ST_MEAN] <= {mean_nxt, ctl0_r};
    end
    // Means and control travel alongside the lanes
    for (int i = ST_MEAN + 1; i < ST_OUT; i++) begin
      if (en[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Distance lanes, one per pixel of the block
  generate
    for (gi = 0; gi < NUM_LANES; gi++) begin : g_lane
      bdwe_lane #(
        .CHANNEL_BITS (CHANNEL_BITS)
      ) u_lane (
        .clk     (clk),
        .en_sq   (en[ST_SQ]),
        .en_rad  (en[ST_RAD]),
        .en_sqrt (en[ST_OUT-1:ST_ROOT0]),
        .pixel   (pix1_r[gi]),
        .mean4   (side_r[ST_MEAN][SIDE_W-1 -: NUM_CHAN*MEAN_BITS]),
        .root    (roots[gi])
      );
    end
  endgenerate

  assign ctl_out = side_r[ST_OUT-1][CTL_BITS-1:0];

  bdwe_merge #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_merge (
    .clk         (clk),
    .en          (en[ST_OUT]),
    .roots       (roots),
    .ctl         (ctl_out),
    .mean4       (side_r[ST_OUT-1][SIDE_W-1 -: NUM_CHAN*MEAN_BITS]),
    .threshold   (threshold_r),
    .mean_red    (out_mean_red),
    .mean_green  (out_mean_green),
    .mean_blue   (out_mean_blue),
    .block_error (out_block_error),
    .merge_block (out_merge_block)
  );

  // Input is held off only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with an empty pipeline stage");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A mean never exceeds four times the largest channel value
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mean_red <= MEAN_MAX && out_mean_green <= MEAN_MAX
                   && out_mean_blue <= MEAN_MAX))
    else $error("mean colour out of range");

endmodule
